### design/spq_pkg.sv
package spq_pkg;

    // width of the count fields on the result port
    localparam int COUNT_OUT_W = 6;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_NULL  = 3'd1,
        ST_DUP   = 3'd2,
        ST_FULL  = 3'd3,
        ST_EMPTY = 3'd4
    } status_t;

    typedef struct packed {
        logic [15:0]        item;
        logic [7:0]         kind;
        logic signed [15:0] prio;
    } entry_t;

    // shift command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } cell_cmd_t;

endpackage

### design/stable_priority_queue.sv
// Bounded min-priority queue built as a row of CAPACITY cells kept in sorted
// order, front at cell 0. Each cell compares its own entry against the
// pending word; an insert shifts every cell holding a strictly larger
// priority one place back and drops the new entry into the gap, so equal
// priorities leave in arrival order. A remove shifts the whole row forward.
// Inserts of a null handle, of a handle already held, or into a full queue
// are refused with the matching status and leave the queue alone. A word is
// latched on acceptance and its result is registered once the output is free
// to take it, and a new word can be taken every cycle while results are
// being taken; the commit path runs through the per-cell compare and the OR over
// all cell match flags for the duplicate check. Counts on the result port
// are the low 6 bits of the held count. Reset empties the queue; cell
// contents are not cleared, only the count.
module stable_priority_queue #(
    parameter int CAPACITY = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [15:0] item_id,
    input  logic [7:0]  entry_kind,
    input  logic signed [15:0] entry_priority,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [5:0]  count_before,
    output logic [5:0]  count_now,
    output logic [15:0] out_item,
    output logic [7:0]  out_kind,
    output logic signed [15:0] out_priority
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // pending word latch
    logic             busy_reg;
    logic             busy_next;
    logic             op_reg;
    entry_t           pend_reg;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // result register
    logic             out_valid_reg;
    logic             out_valid_next;
    status_t          status_reg;
    status_t          status_next;
    logic [COUNT_OUT_W-1:0] before_reg;
    logic [COUNT_OUT_W-1:0] now_reg;
    entry_t           res_reg;
    entry_t           res_next;

    // cell row
    entry_t           cell_entry [CAPACITY];
    logic [CAPACITY-1:0] cell_gt;
    logic [CAPACITY-1:0] cell_match;
    cell_cmd_t        cmd;

    logic             commit;
    logic             accept;
    logic             dup;
    logic             full;
    logic             empty;

    assign commit   = busy_reg && (!out_valid_reg || !out_stall);
    assign in_stall = busy_reg && !commit;
    assign accept   = in_valid && !in_stall;

    assign dup   = |cell_match;
    assign full  = count_reg == CNT_W'(CAPACITY);
    assign empty = count_reg == '0;

    always_comb
    begin
        status_next    = ST_OK;
        res_next       = '0;
        count_next     = count_reg;
        cmd            = '0;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (op_reg == OP_INSERT)
        begin
            if (pend_reg.item == '0)
            begin
                status_next = ST_NULL;
            end
            else if (dup)
            begin
                status_next = ST_DUP;
            end
            else if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                cmd.ins    = commit;
                count_next = commit ? count_reg + 1'b1 : count_reg;
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                res_next   = cell_entry[0];
                cmd.rem    = commit;
                count_next = commit ? count_reg - 1'b1 : count_reg;
            end
        end

        if (commit)
        begin
            out_valid_next = 1'b1;
            busy_next      = 1'b0;
        end
        if (accept)
        begin
            busy_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= opcode;
            pend_reg.item <= item_id;
            pend_reg.kind <= entry_kind;
            pend_reg.prio <= entry_priority;
        end
        if (commit)
        begin
            status_reg <= status_next;
            before_reg <= COUNT_OUT_W'(count_reg);
            now_reg    <= COUNT_OUT_W'(count_next);
            res_reg    <= res_next;
        end
    end

    // row of cells, each linked to its neighbors and fed the shared command, count and pending word
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t prev_e;
        entry_t next_e;
        logic   prev_g;

        if (i == 0)
        begin : g_head
            assign prev_e = '0;
            assign prev_g = 1'b0;
        end
        else
        begin : g_body
            assign prev_e = cell_entry[i-1];
            assign prev_g = cell_gt[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_e = '0;
        end
        else
        begin : g_link
            assign next_e = cell_entry[i+1];
        end

        spq_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .count      (count_reg),
            .new_entry  (pend_reg),
            .prev_entry (prev_e),
            .prev_gt    (prev_g),
            .next_entry (next_e),
            .entry      (cell_entry[i]),
            .gt         (cell_gt[i]),
            .match      (cell_match[i])
        );
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign count_before = before_reg;
    assign count_now    = now_reg;
    assign out_item     = res_reg.item;
    assign out_kind     = res_reg.kind;
    assign out_priority = res_reg.prio;

endmodule

### design/spq_cell.sv
module spq_cell #(
    parameter int CNT_W = 6,
    parameter int INDEX = 0
) (
    input  logic              clk,
    input  spq_pkg::cell_cmd_t cmd,
    input  logic [CNT_W-1:0]  count,
    input  spq_pkg::entry_t   new_entry,
    input  spq_pkg::entry_t   prev_entry,
    input  logic              prev_gt,
    input  spq_pkg::entry_t   next_entry,
    output spq_pkg::entry_t   entry,
    output logic              gt,
    output logic              match
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   occupied;

    assign occupied = CNT_W'(INDEX) < count;
    assign match    = occupied && (entry_reg.item == new_entry.item);
    // free cells count as greater so a new word lands right after the last one
    assign gt       = !occupied || ($signed(entry_reg.prio) > $signed(new_entry.prio));

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins && gt)
        begin
            entry_next = prev_gt ? prev_entry : new_entry;
        end
        else if (cmd.rem)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
